// ===== rtl/itwt_pkg.sv =====
// shared types and constants for the integer to word tokens block
`timescale 1ns / 1ps

package itwt_pkg;

  localparam int unsigned VALUE_W = 31;                 // input integer width
  localparam int unsigned WORD_W  = 5;                  // token code width
  localparam int unsigned NDIG    = 10;                 // decimal digits of a 31-bit value
  localparam int unsigned BCD_W   = 4 * NDIG;           // packed bcd width
  localparam int unsigned GRP_W   = 12;                 // three digits per group
  localparam int unsigned NGRP    = 4;                  // billions .. units
  localparam int unsigned SEQ_W   = GRP_W * NGRP;       // padded bcd in the sequencer
  localparam int unsigned CNT_W   = $clog2(VALUE_W);    // shift counter width
  localparam int unsigned GIDX_W  = $clog2(NGRP);

  localparam logic [WORD_W-1:0] TOK_ZERO    = 5'd0;
  localparam logic [WORD_W-1:0] TOK_HUNDRED = 5'd28;
  localparam logic [WORD_W-1:0] TEEN_BASE   = 5'd10;
  localparam logic [WORD_W-1:0] TENS_BASE   = 5'd18;
  localparam logic [WORD_W-1:0] SCALE_BASE  = 5'd28;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } top_state_e;

  typedef enum logic [2:0] {
    SL_IDLE,
    SL_HUND,
    SL_HWORD,
    SL_TENS,
    SL_ONES,
    SL_SCALE,
    SL_FLUSH
  } slot_e;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
    logic              last;
  } tok_t;

endpackage

// ===== rtl/itwt_bcd.sv =====
// bit-serial binary to bcd converter (shift and add-3)
`timescale 1ns / 1ps

module itwt_bcd import itwt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               done_o,
  output logic [BCD_W-1:0]   bcd_o
);

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [BCD_W-1:0]   adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (load_i) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(VALUE_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== rtl/itwt_seq.sv =====
// token sequencer: walks the digit groups one slot per cycle
`timescale 1ns / 1ps

module itwt_seq import itwt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BCD_W-1:0] bcd_i,
  output tok_t             tok_o
);

  slot_e             slot_q, slot_d;
  logic [SEQ_W-1:0]  grp_q, grp_d;
  logic [GIDX_W-1:0] gidx_q, gidx_d;
  logic              pend_v_q, pend_v_d;
  logic [WORD_W-1:0] pend_w_q, pend_w_d;
  tok_t              tok_q, tok_d;

  logic [3:0]        dig_h, dig_t, dig_o;
  logic              grp_nz;
  logic              emit_v;
  logic [WORD_W-1:0] emit_w;

  // current group sits in the top twelve bits
  assign dig_h  = grp_q[SEQ_W-1   -: 4];
  assign dig_t  = grp_q[SEQ_W-5   -: 4];
  assign dig_o  = grp_q[SEQ_W-9   -: 4];
  assign grp_nz = |grp_q[SEQ_W-1 -: GRP_W];

  always_comb begin
    emit_v = 1'b0;
    emit_w = TOK_ZERO;
    case (slot_q)
      SL_HUND: begin
        emit_v = (dig_h != 4'd0);
        emit_w = {1'b0, dig_h};
      end
      SL_HWORD: begin
        emit_v = (dig_h != 4'd0);
        emit_w = TOK_HUNDRED;
      end
      SL_TENS: begin
        if (dig_t == 4'd1) begin
          emit_v = 1'b1;
          emit_w = {1'b0, dig_o} + TEEN_BASE;
        end else if (dig_t >= 4'd2) begin
          emit_v = 1'b1;
          emit_w = {1'b0, dig_t} + TENS_BASE;
        end else begin
          emit_v = (dig_o != 4'd0);
          emit_w = {1'b0, dig_o};
        end
      end
      SL_ONES: begin
        emit_v = (dig_t >= 4'd2) && (dig_o != 4'd0);
        emit_w = {1'b0, dig_o};
      end
      SL_SCALE: begin
        emit_v = grp_nz && (gidx_q != '0);
        emit_w = SCALE_BASE + WORD_W'(gidx_q);
      end
      default: begin
        emit_v = 1'b0;
        emit_w = TOK_ZERO;
      end
    endcase
  end

  // one-token delay lets the last token be known when it leaves
  always_comb begin
    slot_d   = slot_q;
    grp_d    = grp_q;
    gidx_d   = gidx_q;
    pend_v_d = pend_v_q;
    pend_w_d = pend_w_q;
    tok_d    = '0;
    tok_d.word = pend_w_q;

    if (emit_v) begin
      tok_d.valid = pend_v_q;
      tok_d.word  = pend_w_q;
      pend_v_d    = 1'b1;
      pend_w_d    = emit_w;
    end

    case (slot_q)
      SL_IDLE: begin
        if (start_i) begin
          slot_d   = SL_HUND;
          grp_d    = {{(SEQ_W-BCD_W){1'b0}}, bcd_i};
          gidx_d   = GIDX_W'(NGRP - 1);
          pend_v_d = 1'b0;
        end
      end
      SL_HUND:  slot_d = SL_HWORD;
      SL_HWORD: slot_d = SL_TENS;
      SL_TENS:  slot_d = SL_ONES;
      SL_ONES:  slot_d = SL_SCALE;
      SL_SCALE: begin
        if (gidx_q == '0) begin
          slot_d = SL_FLUSH;
        end else begin
          slot_d = SL_HUND;
          gidx_d = gidx_q - 1'b1;
          grp_d  = {grp_q[SEQ_W-GRP_W-1:0], {GRP_W{1'b0}}};
        end
      end
      SL_FLUSH: begin
        // no token pending means the value was zero
        slot_d      = SL_IDLE;
        tok_d.valid = 1'b1;
        tok_d.last  = 1'b1;
        tok_d.word  = pend_v_q ? pend_w_q : TOK_ZERO;
        pend_v_d    = 1'b0;
      end
      default: slot_d = SL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= SL_IDLE;
      gidx_q   <= '0;
      pend_v_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      slot_q   <= slot_d;
      gidx_q   <= gidx_d;
      pend_v_q <= pend_v_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q    <= grp_d;
    pend_w_q <= pend_w_d;
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/integer_to_word_tokens.sv =====
// top level: spells a 31-bit integer as a run of english word tokens
`timescale 1ns / 1ps

// a transaction is taken when start is high and busy is low; the block then
// stays busy while the bit-serial binary to bcd converter runs (one input
// bit per cycle) and the sequencer then visits five token slots in each of
// the four digit groups, one slot per cycle, and a final flush slot. tokens
// come out on word_o and last_word_o, each for exactly one cycle with
// result_valid_o high; the receiver must take them as they come.
// last_word_o marks the final token, and busy drops the cycle after it, so
// the next transaction can be taken then. zero gives the single token zero.

module integer_to_word_tokens import itwt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value_i,
  output logic               result_valid_o,
  output logic [WORD_W-1:0]  word_o,
  output logic               last_word_o
);

  top_state_e       state_q, state_d;
  logic             load;
  logic             conv_done;
  logic [BCD_W-1:0] bcd;
  tok_t             tok;

  // transaction accepted
  assign load = start && (state_q == ST_IDLE);

  itwt_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .value_i (value_i),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  // conversion done kicks the sequencer with the finished digits
  itwt_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_done),
    .bcd_i   (bcd),
    .tok_o   (tok)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_CONV;
      ST_CONV: if (conv_done) state_d = ST_EMIT;
      // the flagged final token ends the run
      ST_EMIT: if (tok.valid && tok.last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = tok.valid;
  assign word_o         = tok.word;
  assign last_word_o    = tok.last;

endmodule

// ===== rtl/itwt_checker.sv =====
// port-level checker for the integer to word tokens block, with its bind
`timescale 1ns / 1ps

module itwt_checker import itwt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input logic [WORD_W-1:0] word_o,
  input logic              last_word_o
);

  // tokens only appear inside a transaction
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("token outside a transaction");

  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start taken but not busy");

  // zero is only ever a run of its own
  a_zero_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && word_o == TOK_ZERO) |-> last_word_o)
    else $error("zero token inside a longer run");

  // busy ends right after the final token
  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(result_valid_o && last_word_o))
    else $error("busy dropped without a final token");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_word_o) |=> !result_valid_o)
    else $error("token right after the final token");

endmodule

bind integer_to_word_tokens itwt_checker u_itwt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .word_o         (word_o),
  .last_word_o    (last_word_o)
);

// ===== bench/integer_to_word_tokens_tb.sv =====
// self-checking testbench for the integer to word tokens block
`timescale 1ns / 1ps

module integer_to_word_tokens_tb;
  import itwt_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned MAX_CYCLES   = 400000;  // far above the slowest correct run
  localparam int unsigned DRAIN_CYCLES = 64;      // idle time spent watching for stray tokens
  localparam int unsigned MAX_REPORTS  = 40;      // keep the log short on a bad build

  // scale words that the package does not name
  localparam logic [WORD_W-1:0] WORD_THOUSAND = 5'd29;
  localparam logic [WORD_W-1:0] WORD_MILLION  = 5'd30;
  localparam logic [WORD_W-1:0] WORD_BILLION  = 5'd31;

  localparam longint unsigned VALUE_MAX = 64'd2147483647;
  localparam longint unsigned ONE_BILLION = 64'd1000000000;

  // one spoken token as the block should present it
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } spoken_token_t;

  logic               clk_i;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic [VALUE_W-1:0] value_i = '0;
  logic               busy;
  logic               result_valid_o;
  logic [WORD_W-1:0]  word_o;
  logic               last_word_o;

  spoken_token_t pending_tokens[$];   // tokens still owed by the block, oldest first
  int unsigned   last_run_len = 1;    // token count of the value most recently taken
  int unsigned   error_count  = 0;
  int unsigned   cycle_count  = 0;
  bit            idle_on      = 1'b1; // random sender gaps enabled

  integer_to_word_tokens u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .word_o         (word_o),
    .last_word_o    (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // hard stop in case the block hangs or drops tokens
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // spell a value into its english token run and queue it up
  function automatic void spell_value(input logic [VALUE_W-1:0] v);
    int unsigned n;
    int unsigned divisor;
    int unsigned grp;
    int unsigned rest;
    logic [WORD_W-1:0] words[$];
    n = v;
    divisor = 1000000000;
    // zero is the only value that speaks the zero word
    if (n == 0) begin
      words.push_back(TOK_ZERO);
    end
    // billions, millions, thousands, units; zero groups stay silent
    for (int g = 0; g < NGRP; g++) begin
      grp = (n / divisor) % 1000;
      if (grp != 0) begin
        if (grp / 100 != 0) begin
          words.push_back(WORD_W'(grp / 100));
          words.push_back(TOK_HUNDRED);
        end
        rest = grp % 100;
        // one through nineteen go straight through as their own token
        if (rest != 0 && rest < 20) begin
          words.push_back(WORD_W'(rest));
        end else if (rest >= 20) begin
          words.push_back(TENS_BASE + WORD_W'(rest / 10));
          if (rest % 10 != 0) begin
            words.push_back(WORD_W'(rest % 10));
          end
        end
        if (g < NGRP - 1) begin
          words.push_back((g == 0) ? WORD_BILLION :
                          (g == 1) ? WORD_MILLION : WORD_THOUSAND);
        end
      end
      divisor = divisor / 1000;
    end
    foreach (words[i]) begin
      pending_tokens.push_back('{word: words[i], last: (i == words.size() - 1)});
    end
    last_run_len = words.size();
  endfunction

  // compare every strobed token against the oldest one owed
  always @(posedge clk_i) begin
    spoken_token_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("token %0d last %0b with nothing pending",
                                  word_o, last_word_o));
      end else begin
        want = pending_tokens.pop_front();
        if (word_o !== want.word) begin
          report_mismatch($sformatf("word %0d, expected %0d", word_o, want.word));
        end
        if (last_word_o !== want.last) begin
          report_mismatch($sformatf("last_word %0b, expected %0b on word %0d",
                                    last_word_o, want.last, want.word));
        end
      end
    end
  end

  // one transaction: hold start until the block takes it, then maybe idle
  // for a while, anchored to a random phase of the block's work
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int unsigned anchor;
    int unsigned seen;
    int unsigned strobes;
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    spell_value(v);
    anchor = idle_on ? $urandom_range(0, 4) : 0;
    if (anchor != 0) begin
      // drop start now so the held value is not taken twice
      start <= 1'b0;
      case (anchor)
        2: begin
          // gap lands somewhere in the token run
          strobes = $urandom_range(1, last_run_len);
          seen = 0;
          while (seen < strobes) begin
            @(posedge clk_i);
            if (result_valid_o) seen++;
          end
        end
        3: begin
          // gap lands after the block has gone free
          do @(posedge clk_i); while (busy);
        end
        default: ;  // gap lands during the conversion
      endcase
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // mostly well-formed groups: teens, round tens, round hundreds, zeros
  function automatic int unsigned pick_group();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(1, 19);
      2:       return 10 * $urandom_range(2, 9);
      3:       return 100 * $urandom_range(1, 9);
      4:       return 100 * $urandom_range(0, 9) + $urandom_range(10, 19);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  // extremes, every token code and the zero, ten and longest-run cases
  task automatic test_directed_values();
    longint unsigned picks[$];
    picks = '{0, 1, 19, 20, 21, 100, 101, 110, 999, 1000, 1000001, 1000000,
              1000000000, 700000000, 2147483647, 123456789, 1011012013,
              1014015016, 1017018019, 2010000002, 505808, 1920930940,
              950960970, 980990};
    foreach (picks[i]) send_value(VALUE_W'(picks[i]));
  endtask

  task automatic test_random_full_range(input int unsigned count);
    repeat (count) send_value(VALUE_W'($urandom()));
  endtask

  // values built group by group so zero groups and teens show up often
  task automatic test_random_group_patterns(input int unsigned count);
    longint unsigned total;
    repeat (count) begin
      total = ONE_BILLION * $urandom_range(0, 2) + 64'd1000000 * pick_group()
            + 64'd1000 * pick_group() + pick_group();
      if (total > VALUE_MAX) total = total - ONE_BILLION;
      send_value(VALUE_W'(total));
    end
  endtask

  task automatic test_random_small_values(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) send_value(VALUE_W'($urandom_range(0, 20)));
      else send_value(VALUE_W'($urandom_range(0, 999)));
    end
  endtask

  // no sender gaps at all: each value is taken the cycle the block frees up
  task automatic test_back_to_back(input int unsigned count);
    longint unsigned total;
    idle_on = 1'b0;
    repeat (count) begin
      total = ONE_BILLION * $urandom_range(0, 2) + 64'd1000000 * pick_group()
            + 64'd1000 * pick_group() + pick_group();
      if (total > VALUE_MAX) total = total - ONE_BILLION;
      if ($urandom_range(0, 1) == 0) send_value(VALUE_W'($urandom()));
      else send_value(VALUE_W'(total));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_random_full_range(120);
    test_random_group_patterns(140);
    test_random_small_values(60);
    test_back_to_back(60);
    start <= 1'b0;

    // wait out every owed token, then watch for strays
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/itwt_pkg.sv
rtl/itwt_bcd.sv
rtl/itwt_seq.sv
rtl/integer_to_word_tokens.sv
rtl/itwt_checker.sv
bench/integer_to_word_tokens_tb.sv
